/* hw/rtl/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants of the RGB/HSL color converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // action codes
    localparam logic ACT_RGB2HSL = 1'b0;
    localparam logic ACT_HSL2RGB = 1'b1;

    localparam int NUM_LANES = 2;

    typedef struct packed {
        logic        action;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [15:0] hue_in;
        logic [15:0] sat_in;
        logic [15:0] light_in;
    } pix_in_t;

    typedef struct packed {
        logic [15:0] hue_out;
        logic [15:0] sat_out;
        logic [15:0] light_out;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
    } pix_out_t;

endpackage

`default_nettype wire

/* hw/rtl/rhc_front.sv */
// ----------------------------------------------------------------------------
// rhc_front
// Three register stages ahead of the dividers: channel min/max, lightness
// products, and the dividend/divisor setup for both directions.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_front #(
    parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_vld,
    input  wire rhc_pkg::pix_in_t                       pixel,
    output logic                                        div_vld,
    output logic [rhc_pkg::NUM_LANES-1:0][2*FRAC_BITS+1:0] div_num,
    output logic [rhc_pkg::NUM_LANES-1:0][FRAC_BITS+1:0]   div_den,
    output logic [4*FRAC_BITS+7:0]                      div_side
);

    localparam int F    = FRAC_BITS;
    localparam int VW   = F + 1;
    localparam int DIVW = 2 * F + 2;
    localparam int DW   = F + 2;
    localparam int UP   = (F >= 16) ? (F - 16) : 0;
    localparam int DN   = (F < 16) ? (16 - F) : 0;
    // ceil(2^(F+16) / 255): exact reciprocal of 255 for a 9-bit sum
    localparam longint unsigned LMUL = ((64'd1 << (F + 16)) + 64'd254) / 64'd255;

    typedef struct packed {
        logic            act;
        logic            grey;
        logic [7:0]      d;
        logic [8:0]      sum;
        logic [7:0]      den;
        logic [10:0]     num;
        logic [10:0]     d6;
        logic [F-1:0]    h;
        logic [F-1:0]    s;
        logic [F-1:0]    l;
        logic [2*F-1:0]  ls;
    } sta_t;

    typedef struct packed {
        logic            act;
        logic            grey;
        logic [7:0]      d;
        logic [8:0]      sum;
        logic [7:0]      den;
        logic [10:0]     num;
        logic [10:0]     d6;
        logic [2:0]      sext;
        logic [F-1:0]    fr;
        logic [F-1:0]    l;
        logic [VW-1:0]   v;
    } stb_t;

    typedef struct packed {
        logic            act;
        logic            grey;
        logic [VW-1:0]   v;
        logic [VW-1:0]   m;
        logic [2:0]      sext;
        logic [F-1:0]    fr;
        logic [F:0]      lq;
    } side_t;

    sta_t a_reg, a_next;
    stb_t b_reg, b_next;
    logic a_vld_reg, b_vld_reg, c_vld_reg;
    logic [rhc_pkg::NUM_LANES-1:0][DIVW-1:0] num_reg, num_next;
    logic [rhc_pkg::NUM_LANES-1:0][DW-1:0]   den_reg, den_next;
    side_t side_reg, side_next;

    logic [7:0]        mx, mn, dd;
    logic [8:0]        sm, dn9;
    logic signed [11:0] nraw, nadj;
    logic [10:0]       d6w;
    logic [F+15:0]     hx, sx, lx;
    logic [F-1:0]      ls_hi;
    logic [F:0]        lps;
    logic [F+2:0]      h6;
    logic [VW-1:0]     l2, mm, diff;
    logic [F+17:0]     lprod;

    // stage A: channel extremes and the hue numerator
    always_comb
    begin
        mx = pixel.red_in;
        mn = pixel.red_in;
        if (pixel.green_in > mx) mx = pixel.green_in;
        if (pixel.blue_in > mx)  mx = pixel.blue_in;
        if (pixel.green_in < mn) mn = pixel.green_in;
        if (pixel.blue_in < mn)  mn = pixel.blue_in;
        dd  = mx - mn;
        sm  = {1'b0, mx} + {1'b0, mn};
        dn9 = (sm < 9'd255) ? sm : (9'd510 - sm);
        if (dn9 == 9'd0)
            dn9 = 9'd1;
        d6w = {1'b0, dd, 2'b00} + {2'b00, dd, 1'b0};
        if (pixel.red_in == mx)
            nraw = $signed({4'd0, pixel.green_in}) - $signed({4'd0, pixel.blue_in});
        else if (pixel.green_in == mx)
            nraw = $signed({3'd0, dd, 1'b0}) + $signed({4'd0, pixel.blue_in})
                 - $signed({4'd0, pixel.red_in});
        else
            nraw = $signed({2'd0, dd, 2'b00}) + $signed({4'd0, pixel.red_in})
                 - $signed({4'd0, pixel.green_in});
        nadj = (nraw < 0) ? (nraw + $signed({1'b0, d6w})) : nraw;

        hx = ({{F{1'b0}}, pixel.hue_in} << UP) >> DN;
        sx = ({{F{1'b0}}, pixel.sat_in} << UP) >> DN;
        lx = ({{F{1'b0}}, pixel.light_in} << UP) >> DN;

        a_next.act  = pixel.action;
        a_next.grey = (dd == 8'd0);
        a_next.d    = dd;
        a_next.sum  = sm;
        a_next.den  = dn9[7:0];
        a_next.num  = nadj[10:0];
        a_next.d6   = d6w;
        a_next.h    = hx[F-1:0];
        a_next.s    = sx[F-1:0];
        a_next.l    = lx[F-1:0];
        a_next.ls   = lx[F-1:0] * sx[F-1:0];
    end

    // stage B: the v term and the hue sextant
    always_comb
    begin
        ls_hi = a_reg.ls[2*F-1:F];
        lps   = {1'b0, a_reg.l} + {1'b0, a_reg.s};
        h6    = {a_reg.h, 2'b00} + {1'b0, a_reg.h, 1'b0};
        b_next.act  = a_reg.act;
        b_next.grey = a_reg.grey;
        b_next.d    = a_reg.d;
        b_next.sum  = a_reg.sum;
        b_next.den  = a_reg.den;
        b_next.num  = a_reg.num;
        b_next.d6   = a_reg.d6;
        b_next.sext = h6[F+2:F];
        b_next.fr   = h6[F-1:0];
        b_next.l    = a_reg.l;
        if (a_reg.l <= (F'(1) << (F - 1)))
            b_next.v = {1'b0, a_reg.l} + {1'b0, ls_hi};
        else
            b_next.v = (lps > {1'b0, ls_hi}) ? (lps - {1'b0, ls_hi}) : '0;
    end

    // stage C: m, v - m, lightness, and the divider operands
    always_comb
    begin
        l2   = {b_reg.l, 1'b0};
        mm   = (l2 > b_reg.v) ? (l2 - b_reg.v) : '0;
        diff = (b_reg.v > mm) ? (b_reg.v - mm) : '0;
        // sum * 2^F / 510 as sum * 2^(F-1) / 255 by reciprocal multiply
        lprod = {{(F+9){1'b0}}, b_reg.sum} * LMUL[F+17:0];
        if (b_reg.act == rhc_pkg::ACT_RGB2HSL)
        begin
            num_next[0] = DIVW'(b_reg.d) << F;
            den_next[0] = DW'(b_reg.den);
        end
        else
        begin
            num_next[0] = DIVW'(diff) << F;
            den_next[0] = DW'(b_reg.v);
        end
        num_next[1] = DIVW'(b_reg.num) << F;
        den_next[1] = DW'(b_reg.d6);
        side_next.act  = b_reg.act;
        side_next.grey = b_reg.grey;
        side_next.v    = b_reg.v;
        side_next.m    = mm;
        side_next.sext = b_reg.sext;
        side_next.fr   = b_reg.fr;
        side_next.lq   = lprod[F+17:17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        side_reg <= side_next;
    end

    assign div_vld  = c_vld_reg;
    assign div_num  = num_reg;
    assign div_den  = den_reg;
    assign div_side = side_reg;

endmodule

`default_nettype wire

/* hw/rtl/rhc_div.sv */
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per stage, several lanes in
// lockstep with a side payload that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div #(
    parameter int LANES = rhc_pkg::NUM_LANES,
    parameter int NW    = 34,
    parameter int DW    = 18,
    parameter int SW    = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_vld,
    input  wire logic [LANES-1:0][NW-1:0]    num,
    input  wire logic [LANES-1:0][DW-1:0]    den,
    input  wire logic [SW-1:0]               side_in,
    output logic                             out_vld,
    output logic [LANES-1:0][NW-1:0]         quo,
    output logic [SW-1:0]                    side_out
);

    logic [LANES-1:0][DW-1:0] rem_reg [NW];
    logic [LANES-1:0][DW-1:0] rem_next [NW];
    logic [LANES-1:0][NW-1:0] nq_reg [NW];
    logic [LANES-1:0][NW-1:0] nq_next [NW];
    logic [LANES-1:0][DW-1:0] dv_reg [NW];
    logic [LANES-1:0][DW-1:0] dv_next [NW];
    logic [SW-1:0]            side_reg [NW];
    logic [SW-1:0]            side_next [NW];
    logic [NW-1:0]            vld_reg, vld_next;

    logic [LANES-1:0][DW-1:0] src_rem [NW];
    logic [LANES-1:0][NW-1:0] src_nq [NW];
    logic [LANES-1:0][DW-1:0] src_dv [NW];
    logic [LANES-1:0][DW:0]   trial [NW];
    logic [LANES-1:0]         ge [NW];

    always_comb
    begin
        for (int k = 0; k < NW; k++)
        begin
            if (k == 0)
            begin
                src_rem[k]   = '0;
                src_nq[k]    = num;
                src_dv[k]    = den;
                side_next[k] = side_in;
                vld_next[k]  = in_vld;
            end
            else
            begin
                src_rem[k]   = rem_reg[k-1];
                src_nq[k]    = nq_reg[k-1];
                src_dv[k]    = dv_reg[k-1];
                side_next[k] = side_reg[k-1];
                vld_next[k]  = vld_reg[k-1];
            end
            for (int j = 0; j < LANES; j++)
            begin
                // shift in the next dividend bit, subtract when it fits
                trial[k][j] = {src_rem[k][j], src_nq[k][j][NW-1]};
                ge[k][j]    = (trial[k][j] >= {1'b0, src_dv[k][j]});
                rem_next[k][j] = ge[k][j] ? DW'(trial[k][j] - {1'b0, src_dv[k][j]})
                                          : trial[k][j][DW-1:0];
                nq_next[k][j]  = {src_nq[k][j][NW-2:0], ge[k][j]};
                dv_next[k][j]  = src_dv[k][j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NW; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            nq_reg[k]   <= nq_next[k];
            dv_reg[k]   <= dv_next[k];
            side_reg[k] <= side_next[k];
        end
    end

    assign out_vld  = vld_reg[NW-1];
    assign quo      = nq_reg[NW-1];
    assign side_out = side_reg[NW-1];

endmodule

`default_nettype wire

/* hw/rtl/rhc_back.sv */
// ----------------------------------------------------------------------------
// rhc_back
// Four register stages after the dividers: HSL result scaling, the sextant
// interpolation products, channel selection and conversion to bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_back #(
    parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_vld,
    input  wire logic [rhc_pkg::NUM_LANES-1:0][2*FRAC_BITS+1:0] quo,
    input  wire logic [4*FRAC_BITS+7:0]                    side,
    output logic                                           done,
    output rhc_pkg::pix_out_t                              result
);

    localparam int F    = FRAC_BITS;
    localparam int VW   = F + 1;
    localparam int DIVW = 2 * F + 2;
    localparam int UP   = (F >= 16) ? (F - 16) : 0;
    localparam int DN   = (F < 16) ? (16 - F) : 0;

    typedef struct packed {
        logic            act;
        logic            grey;
        logic [VW-1:0]   v;
        logic [VW-1:0]   m;
        logic [2:0]      sext;
        logic [F-1:0]    fr;
        logic [F:0]      lq;
    } side_t;

    typedef struct packed {
        logic            act;
        logic            vz;
        logic [15:0]     hue;
        logic [15:0]     sat;
        logic [15:0]     light;
        logic [VW-1:0]   t;
        logic [VW-1:0]   v;
        logic [VW-1:0]   m;
        logic [2:0]      sext;
        logic [F-1:0]    fr;
    } st1_t;

    typedef struct packed {
        logic            act;
        logic            vz;
        logic [15:0]     hue;
        logic [15:0]     sat;
        logic [15:0]     light;
        logic [VW-1:0]   vsf;
        logic [VW-1:0]   v;
        logic [VW-1:0]   m;
        logic [2:0]      sext;
    } st2_t;

    typedef struct packed {
        logic            act;
        logic [15:0]     hue;
        logic [15:0]     sat;
        logic [15:0]     light;
        logic [VW:0]     cr;
        logic [VW:0]     cg;
        logic [VW:0]     cb;
    } st3_t;

    function automatic logic [15:0] to16(input logic [DIVW-1:0] q);
        logic [DIVW+5:0] w;
        w = ({6'd0, q} >> UP) << DN;
        return (|w[DIVW+5:16]) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [7:0] to_byte(input logic [VW:0] x);
        logic [VW+8:0] p;
        logic [VW+8:0] s;
        p = {x, 8'd0} - {8'd0, x};
        s = p >> F;
        return (|s[VW+8:8]) ? 8'hFF : s[7:0];
    endfunction

    side_t sd;
    st1_t  s1_reg, s1_next;
    st2_t  s2_reg, s2_next;
    st3_t  s3_reg, s3_next;
    rhc_pkg::pix_out_t out_reg, out_next;
    logic  v1_reg, v2_reg, v3_reg, v4_reg;

    logic [VW+F:0]   p_vs;
    logic [VW+F-1:0] p_tf;
    logic [VW:0]     mid1, mid2, vx, mx0;

    // stage 1: scale HSL quotients, form v*sv
    always_comb
    begin
        sd = side_t'(side);
        p_vs = sd.v * quo[0][F:0];
        s1_next.act  = sd.act;
        s1_next.vz   = (sd.v == '0);
        s1_next.hue  = (sd.act == rhc_pkg::ACT_RGB2HSL && !sd.grey) ? to16(quo[1]) : 16'd0;
        s1_next.sat  = (sd.act == rhc_pkg::ACT_RGB2HSL && !sd.grey) ? to16(quo[0]) : 16'd0;
        s1_next.light = (sd.act == rhc_pkg::ACT_RGB2HSL) ? to16(DIVW'(sd.lq)) : 16'd0;
        s1_next.t    = p_vs[VW+F-1:F];
        s1_next.v    = sd.v;
        s1_next.m    = sd.m;
        s1_next.sext = sd.sext;
        s1_next.fr   = sd.fr;
    end

    // stage 2: scale by the sextant fraction
    always_comb
    begin
        p_tf = s1_reg.t * s1_reg.fr;
        s2_next.act   = s1_reg.act;
        s2_next.vz    = s1_reg.vz;
        s2_next.hue   = s1_reg.hue;
        s2_next.sat   = s1_reg.sat;
        s2_next.light = s1_reg.light;
        s2_next.vsf   = p_tf[VW+F-1:F];
        s2_next.v     = s1_reg.v;
        s2_next.m     = s1_reg.m;
        s2_next.sext  = s1_reg.sext;
    end

    // stage 3: pick channel values by sextant
    always_comb
    begin
        vx   = {1'b0, s2_reg.v};
        mx0  = {1'b0, s2_reg.m};
        mid1 = mx0 + {1'b0, s2_reg.vsf};
        mid2 = (s2_reg.v > s2_reg.vsf) ? {1'b0, s2_reg.v - s2_reg.vsf} : '0;
        s3_next.act   = s2_reg.act;
        s3_next.hue   = s2_reg.hue;
        s3_next.sat   = s2_reg.sat;
        s3_next.light = s2_reg.light;
        case (s2_reg.sext)
            3'd0:
            begin
                s3_next.cr = vx;   s3_next.cg = mid1; s3_next.cb = mx0;
            end
            3'd1:
            begin
                s3_next.cr = mid2; s3_next.cg = vx;   s3_next.cb = mx0;
            end
            3'd2:
            begin
                s3_next.cr = mx0;  s3_next.cg = vx;   s3_next.cb = mid1;
            end
            3'd3:
            begin
                s3_next.cr = mx0;  s3_next.cg = mid2; s3_next.cb = vx;
            end
            3'd4:
            begin
                s3_next.cr = mid1; s3_next.cg = mx0;  s3_next.cb = vx;
            end
            default:
            begin
                s3_next.cr = vx;   s3_next.cg = mx0;  s3_next.cb = mid2;
            end
        endcase
        // zero lightness gives black
        if (s2_reg.vz)
        begin
            s3_next.cr = '0;
            s3_next.cg = '0;
            s3_next.cb = '0;
        end
    end

    // stage 4: bytes out, zero the fields of the other direction
    always_comb
    begin
        out_next.hue_out   = s3_reg.hue;
        out_next.sat_out   = s3_reg.sat;
        out_next.light_out = s3_reg.light;
        if (s3_reg.act == rhc_pkg::ACT_HSL2RGB)
        begin
            out_next.red_out   = to_byte(s3_reg.cr);
            out_next.green_out = to_byte(s3_reg.cg);
            out_next.blue_out  = to_byte(s3_reg.cb);
        end
        else
        begin
            out_next.red_out   = 8'd0;
            out_next.green_out = 8'd0;
            out_next.blue_out  = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        s2_reg  <= s2_next;
        s3_reg  <= s3_next;
        out_reg <= out_next;
    end

    assign done   = v4_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

/* hw/rtl/rgb_hsl_color_converter.sv */
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter
// Per-pixel RGB to HSL and HSL to RGB conversion, fully pipelined.
// ----------------------------------------------------------------------------
// One pixel can be started every clock; busy never rises. Each result appears
// for a single cycle with done high. The pipeline is made of the restoring
// dividers, which resolve one quotient bit per pipeline stage over a
// 2*FRAC_BITS+2 bit dividend, with three setup stages ahead of them and four
// output stages after them.
// The receiver cannot stall, so it must take every result when done is high.
`default_nettype none

module rgb_hsl_color_converter #(
    parameter int FRAC_BITS = rhc_pkg::FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire rhc_pkg::pix_in_t  pixel,
    output logic                   done,
    output rhc_pkg::pix_out_t      result
);

    localparam int DIVW = 2 * FRAC_BITS + 2;
    localparam int DW   = FRAC_BITS + 2;
    localparam int SW   = 4 * FRAC_BITS + 8;
    localparam int LAT  = 3 + DIVW + 4;

    logic                                    div_vld, quo_vld;
    logic [rhc_pkg::NUM_LANES-1:0][DIVW-1:0] div_num, quo;
    logic [rhc_pkg::NUM_LANES-1:0][DW-1:0]   div_den;
    logic [SW-1:0]                           div_side, quo_side;

    assign busy = 1'b0;

    rhc_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (start),
        .pixel    (pixel),
        .div_vld  (div_vld),
        .div_num  (div_num),
        .div_den  (div_den),
        .div_side (div_side)
    );

    rhc_div #(
        .LANES (rhc_pkg::NUM_LANES),
        .NW    (DIVW),
        .DW    (DW),
        .SW    (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (div_vld),
        .num      (div_num),
        .den      (div_den),
        .side_in  (div_side),
        .out_vld  (quo_vld),
        .quo      (quo),
        .side_out (quo_side)
    );

    rhc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_vld (quo_vld),
        .quo    (quo),
        .side   (quo_side),
        .done   (done),
        .result (result)
    );

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("transfer did not produce a result at the fixed latency");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a matching start");

    a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.red_out == 8'd0 && result.green_out == 8'd0
                   && result.blue_out == 8'd0)
               || (result.hue_out == 16'd0 && result.sat_out == 16'd0
                   && result.light_out == 16'd0)))
        else $error("fields of both directions set in one result");

    a_dir_rgb: assert property (@(posedge clk) disable iff (!rst_n)
        (start && pixel.action == rhc_pkg::ACT_RGB2HSL) |-> ##LAT
        (result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0))
        else $error("RGB to HSL result carries color bytes");

endmodule

`default_nettype wire
